[rtl/mri_pkg.sv]
package mri_pkg;

  // event kinds
  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_REPLY = 2'd1;
  localparam logic [1:0] MODE_TX    = 2'd2;

  // command bytes
  localparam logic [7:0] CMD_OFF = 8'h00;
  localparam logic [7:0] CMD_FWD = 8'h80;
  localparam logic [7:0] CMD_REV = 8'hC0;

  // sum of the fixed frame bytes 55 aa 03 20 80
  localparam logic [7:0] FRAME_SUM_BASE = 8'hA2;

  // register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DWELL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_CONFIRM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_MAX_AGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_REPORT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORBID_REV    = 3'd4;

  // register reset values
  localparam logic [15:0] OFF_DWELL_RST     = 16'd1000;
  localparam logic [15:0] ZERO_CONFIRM_RST  = 16'd300;
  localparam logic [15:0] REPLY_MAX_AGE_RST = 16'd300;
  localparam logic [15:0] WAIT_REPORT_RST   = 16'd5000;

  typedef struct packed {
    logic [15:0] off_dwell_ms;
    logic [15:0] zero_confirm_ms;
    logic [15:0] reply_max_age_ms;
    logic [15:0] wait_report_ms;
    logic        forbid_reverse;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic        on_request;
    logic        direction_request;
    logic        reply_framed;
    logic        reply_active;
    logic [7:0]  reply_error;
    logic [15:0] reply_speed;
    logic        tx_ready;
  } item_t;

  typedef struct packed {
    logic [7:0]  command;
    logic [7:0]  check_byte;
    logic        frame_sent;
    logic        motor_active;
    logic [15:0] speed_report;
    logic        reversal_pending;
    logic [31:0] error_count;
  } result_t;

  typedef struct packed {
    logic        run_enabled;
    logic        wanted_direction;
    logic        running_direction;
    logic        pending_flag;
    logic        off_sent_flag;
    logic        zero_seen_flag;
    logic [31:0] stop_time;
    logic [31:0] zero_start_time;
    logic [31:0] pending_report_time;
    logic [31:0] consumed_reply_seq;
    logic [31:0] seen_epoch;
    logic [31:0] reply_seq;
    logic [31:0] reply_epoch;
    logic [31:0] reply_time;
    logic        reply_good;
    logic        last_active;
    logic [7:0]  last_fault;
    logic [15:0] last_speed;
    logic [31:0] fault_total;
  } state_t;

endpackage

[rtl/mri_step.sv]
module mri_step (
  input  mri_pkg::state_t  cur,
  input  mri_pkg::cfg_t    cfg,
  input  mri_pkg::item_t   item,
  output mri_pkg::state_t  nxt,
  output mri_pkg::result_t res
);

  logic [7:0] cmd;
  logic       sent;
  logic       qual;

  always_comb begin
    nxt  = cur;
    cmd  = mri_pkg::CMD_OFF;
    sent = 1'b0;
    qual = 1'b0;

    case (item.mode)
      mri_pkg::MODE_SET: begin
        nxt.run_enabled      = item.on_request;
        nxt.wanted_direction = item.direction_request;
        if (!item.on_request) begin
          nxt.pending_flag   = 1'b0;
          nxt.off_sent_flag  = 1'b0;
          nxt.zero_seen_flag = 1'b0;
        end
      end

      mri_pkg::MODE_REPLY: begin
        nxt.reply_good = item.reply_framed;
        nxt.last_fault = item.reply_error;
        if (item.reply_framed) begin
          nxt.last_active = item.reply_active;
          nxt.last_speed  = item.reply_speed;
        end
        // any reply that is not a fresh clean zero breaks the zero run
        if (!nxt.reply_good || nxt.last_active || nxt.last_fault != 8'd0 ||
            nxt.last_speed != 16'd0 ||
            32'(item.now_ms - cur.reply_time) > {16'd0, cfg.reply_max_age_ms}) begin
          nxt.reply_epoch = cur.reply_epoch + 32'd1;
        end
        nxt.reply_time = item.now_ms;
        nxt.reply_seq  = cur.reply_seq + 32'd1;
      end

      mri_pkg::MODE_TX: begin
        // fault check runs on every slot
        if (cur.last_fault != 8'd0) begin
          nxt.run_enabled    = 1'b0;
          nxt.pending_flag   = 1'b0;
          nxt.off_sent_flag  = 1'b0;
          nxt.zero_seen_flag = 1'b0;
          nxt.fault_total    = nxt.fault_total + 32'd1;
        end
        // slow reversal report
        if (nxt.pending_flag &&
            32'(item.now_ms - cur.pending_report_time) >= {16'd0, cfg.wait_report_ms}) begin
          nxt.pending_report_time = item.now_ms;
          nxt.fault_total         = nxt.fault_total + 32'd1;
        end

        if (item.tx_ready) begin
          if (!nxt.run_enabled) begin
            nxt.pending_flag   = 1'b0;
            nxt.off_sent_flag  = 1'b0;
            nxt.zero_seen_flag = 1'b0;
          end else begin
            if (!nxt.pending_flag && nxt.wanted_direction != nxt.running_direction) begin
              nxt.pending_flag        = 1'b1;
              nxt.off_sent_flag       = 1'b0;
              nxt.zero_seen_flag      = 1'b0;
              nxt.pending_report_time = item.now_ms;
            end

            if (nxt.pending_flag) begin
              // zero speed qualification
              if (nxt.reply_epoch != nxt.seen_epoch) begin
                nxt.zero_seen_flag = 1'b0;
                nxt.seen_epoch     = nxt.reply_epoch;
              end
              if (!nxt.off_sent_flag || !nxt.reply_good || nxt.last_active ||
                  nxt.last_fault != 8'd0 || nxt.last_speed != 16'd0 ||
                  32'(item.now_ms - nxt.reply_time) > {16'd0, cfg.reply_max_age_ms}) begin
                nxt.zero_seen_flag     = 1'b0;
                nxt.consumed_reply_seq = nxt.reply_seq;
              end else if (nxt.reply_seq != nxt.consumed_reply_seq) begin
                nxt.consumed_reply_seq = nxt.reply_seq;
                if (!nxt.zero_seen_flag) begin
                  nxt.zero_start_time = nxt.reply_time;
                  nxt.zero_seen_flag  = 1'b1;
                end
                qual = !cfg.forbid_reverse &&
                  32'(nxt.reply_time - nxt.zero_start_time) >= {16'd0, cfg.zero_confirm_ms} &&
                  32'(item.now_ms - nxt.stop_time) >= {16'd0, cfg.off_dwell_ms};
              end
            end

            if (!nxt.pending_flag || qual) begin
              cmd = nxt.wanted_direction ? mri_pkg::CMD_REV : mri_pkg::CMD_FWD;
            end
          end

          sent = 1'b1;
          if (cmd[7]) begin
            nxt.running_direction = nxt.wanted_direction;
            nxt.pending_flag      = 1'b0;
          end else if (nxt.pending_flag && !nxt.off_sent_flag) begin
            nxt.stop_time          = item.now_ms;
            nxt.consumed_reply_seq = nxt.reply_seq;
            nxt.off_sent_flag      = 1'b1;
          end
        end
      end

      default: begin
        // unused mode only reports status
      end
    endcase

    res.command          = sent ? cmd : mri_pkg::CMD_OFF;
    res.check_byte       = sent ? 8'(mri_pkg::FRAME_SUM_BASE + cmd) : 8'd0;
    res.frame_sent       = sent;
    res.motor_active     = nxt.last_active;
    res.speed_report     = nxt.last_speed;
    res.reversal_pending = nxt.pending_flag;
    res.error_count      = nxt.fault_total;
  end

endmodule

[rtl/motor_reversal_interlock_unit.sv]
// Direction-reversal interlock for a motor speed controller. Each input
// transaction is one time-stamped event (set request, decoded controller reply
// or transmit slot) and yields exactly one result transaction carrying the
// command byte and checksum (zero unless a frame was issued) plus status. The
// unit takes one event per clock when the result side keeps up; an event passes
// through two registers, the event register and the result register, and the
// interlock state is updated in the single cycle an event moves between them.
// Configuration registers are written through the cfg channel, which is always
// ready; write them only while no event is in flight.
module motor_reversal_interlock_unit (
  input  logic                            clk,
  input  logic                            rst,

  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mri_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data,

  // event channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      mode,
  input  logic [31:0]                     now_ms,
  input  logic                            on_request,
  input  logic                            direction_request,
  input  logic                            reply_framed,
  input  logic                            reply_active,
  input  logic [7:0]                      reply_error,
  input  logic [15:0]                     reply_speed,
  input  logic                            tx_ready,

  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      command,
  output logic [7:0]                      check_byte,
  output logic                            frame_sent,
  output logic                            motor_active,
  output logic [15:0]                     speed_report,
  output logic                            reversal_pending,
  output logic [31:0]                     error_count
);

  mri_pkg::cfg_t    cfg;
  mri_pkg::state_t  st;
  mri_pkg::state_t  st_next;
  mri_pkg::item_t   item;
  mri_pkg::item_t   item_in;
  mri_pkg::result_t res;
  mri_pkg::result_t res_next;
  logic             item_full;
  logic             res_full;
  logic             advance;

  // config port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.off_dwell_ms     <= mri_pkg::OFF_DWELL_RST;
      cfg.zero_confirm_ms  <= mri_pkg::ZERO_CONFIRM_RST;
      cfg.reply_max_age_ms <= mri_pkg::REPLY_MAX_AGE_RST;
      cfg.wait_report_ms   <= mri_pkg::WAIT_REPORT_RST;
      cfg.forbid_reverse   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mri_pkg::REG_OFF_DWELL:     cfg.off_dwell_ms     <= cfg_data;
        mri_pkg::REG_ZERO_CONFIRM:  cfg.zero_confirm_ms  <= cfg_data;
        mri_pkg::REG_REPLY_MAX_AGE: cfg.reply_max_age_ms <= cfg_data;
        mri_pkg::REG_WAIT_REPORT:   cfg.wait_report_ms   <= cfg_data;
        mri_pkg::REG_FORBID_REV:    cfg.forbid_reverse   <= cfg_data[0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // event moves into the result register when that register is free or drains
  assign advance  = item_full && (!res_full || out_ready);
  assign in_ready = !item_full || advance;

  assign item_in = '{
    mode:              mode,
    now_ms:            now_ms,
    on_request:        on_request,
    direction_request: direction_request,
    reply_framed:      reply_framed,
    reply_active:      reply_active,
    reply_error:       reply_error,
    reply_speed:       reply_speed,
    tx_ready:          tx_ready
  };

  // event register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (in_ready) begin
      item_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

  // interlock update for the event in the event register
  mri_step u_step (
    .cur  (st),
    .cfg  (cfg),
    .item (item),
    .nxt  (st_next),
    .res  (res_next)
  );

  // interlock state commits only when the event leaves the event register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= 1'b1;
    end else if (out_ready) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign out_valid        = res_full;
  assign command          = res.command;
  assign check_byte       = res.check_byte;
  assign frame_sent       = res.frame_sent;
  assign motor_active     = res.motor_active;
  assign speed_report     = res.speed_report;
  assign reversal_pending = res.reversal_pending;
  assign error_count      = res.error_count;

endmodule

[dv/tb_top.sv]
module tb_top;

  // mode 3 is not a real event kind, the unit must only report status
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // cycles with no transaction on any channel before the run is abandoned
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  // directed sequence starts just before the millisecond counter wraps
  localparam logic [31:0] T0 = 32'hFFFF_FC00;

  typedef enum int unsigned {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_style_t;

  // tracks the interlock and holds the results still owed by the unit
  class interlock_tracker;
    // register copies
    logic [15:0] dwell_ms, confirm_ms, max_age_ms, report_ms;
    logic        no_reverse;
    // interlock state
    bit        run_on, want_dir, run_dir, waiting, off_done, zero_run;
    bit        reply_ok, active_seen;
    bit [31:0] stop_at, zero_since, report_at, consumed_seq, epoch_seen;
    bit [31:0] seq, epoch, reply_at, faults;
    bit [7:0]  fault_byte;
    bit [15:0] speed_seen;
    mri_pkg::result_t due_results[$];
    int unsigned mismatches;

    function new();
      dwell_ms   = mri_pkg::OFF_DWELL_RST;
      confirm_ms = mri_pkg::ZERO_CONFIRM_RST;
      max_age_ms = mri_pkg::REPLY_MAX_AGE_RST;
      report_ms  = mri_pkg::WAIT_REPORT_RST;
      no_reverse = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [mri_pkg::CFG_IDX_W-1:0] idx,
                            input logic [15:0] data);
      case (idx)
        mri_pkg::REG_OFF_DWELL:     dwell_ms   = data;
        mri_pkg::REG_ZERO_CONFIRM:  confirm_ms = data;
        mri_pkg::REG_REPLY_MAX_AGE: max_age_ms = data;
        mri_pkg::REG_WAIT_REPORT:   report_ms  = data;
        mri_pkg::REG_FORBID_REV:    no_reverse = data[0];
        default: ;
      endcase
    endfunction

    function void drop_reversal();
      waiting  = 1'b0;
      off_done = 1'b0;
      zero_run = 1'b0;
    endfunction

    // true once a fresh run of zero-speed replies has lasted long enough
    function bit zero_confirmed(input bit [31:0] now);
      bit [31:0] age, held, dwelt;
      if (epoch != epoch_seen) begin
        zero_run   = 1'b0;
        epoch_seen = epoch;
      end
      age = now - reply_at;
      if (!off_done || !reply_ok || active_seen || fault_byte != 0 || speed_seen != 0 ||
          age > max_age_ms) begin
        zero_run     = 1'b0;
        consumed_seq = seq;
        return 1'b0;
      end
      if (seq == consumed_seq) return 1'b0;
      consumed_seq = seq;
      if (!zero_run) begin
        zero_since = reply_at;
        zero_run   = 1'b1;
      end
      held  = reply_at - zero_since;
      dwelt = now - stop_at;
      return !no_reverse && held >= confirm_ms && dwelt >= dwell_ms;
    endfunction

    function void take_event(input mri_pkg::item_t ev);
      bit [7:0]  cmd;
      bit        sent;
      bit [31:0] age;
      mri_pkg::result_t r;
      cmd  = mri_pkg::CMD_OFF;
      sent = 1'b0;
      case (ev.mode)
        mri_pkg::MODE_SET: begin
          run_on   = ev.on_request;
          want_dir = ev.direction_request;
          if (!run_on) drop_reversal();
        end
        mri_pkg::MODE_REPLY: begin
          reply_ok   = ev.reply_framed;
          fault_byte = ev.reply_error;
          if (reply_ok) begin
            active_seen = ev.reply_active;
            speed_seen  = ev.reply_speed;
          end
          age = ev.now_ms - reply_at;
          if (!reply_ok || active_seen || fault_byte != 0 || speed_seen != 0 ||
              age > max_age_ms)
            epoch++;
          reply_at = ev.now_ms;
          seq++;
        end
        mri_pkg::MODE_TX: begin
          // fault check runs on every slot, ready or not
          if (fault_byte != 0) begin
            run_on = 1'b0;
            drop_reversal();
            faults++;
          end
          age = ev.now_ms - report_at;
          if (waiting && age >= report_ms) begin
            report_at = ev.now_ms;
            faults++;
          end
          if (ev.tx_ready) begin
            if (!run_on) begin
              drop_reversal();
            end else begin
              if (!waiting && want_dir != run_dir) begin
                waiting   = 1'b1;
                off_done  = 1'b0;
                zero_run  = 1'b0;
                report_at = ev.now_ms;
              end
              if (!waiting || zero_confirmed(ev.now_ms))
                cmd = want_dir ? mri_pkg::CMD_REV : mri_pkg::CMD_FWD;
            end
            sent = 1'b1;
            if (cmd[7]) begin
              run_dir = want_dir;
              waiting = 1'b0;
            end else if (waiting && !off_done) begin
              stop_at      = ev.now_ms;
              consumed_seq = seq;
              off_done     = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.command          = sent ? cmd : mri_pkg::CMD_OFF;
      r.check_byte       = sent ? mri_pkg::FRAME_SUM_BASE + cmd : 8'h00;
      r.frame_sent       = sent;
      r.motor_active     = active_seen;
      r.speed_report     = speed_seen;
      r.reversal_pending = waiting;
      r.error_count      = faults;
      due_results.push_back(r);
    endfunction

    function void compare(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input mri_pkg::result_t got);
      mri_pkg::result_t want;
      if (due_results.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare("command", 32'(want.command), 32'(got.command));
      compare("check_byte", 32'(want.check_byte), 32'(got.check_byte));
      compare("frame_sent", 32'(want.frame_sent), 32'(got.frame_sent));
      compare("motor_active", 32'(want.motor_active), 32'(got.motor_active));
      compare("speed_report", 32'(want.speed_report), 32'(got.speed_report));
      compare("reversal_pending", 32'(want.reversal_pending), 32'(got.reversal_pending));
      compare("error_count", want.error_count, got.error_count);
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction
  endclass

  // clock, reset and every unit input start at known values
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [mri_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                   cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = '0;
  logic [31:0] now_ms = '0;
  logic        on_request = 1'b0;
  logic        direction_request = 1'b0;
  logic        reply_framed = 1'b0;
  logic        reply_active = 1'b0;
  logic [7:0]  reply_error = '0;
  logic [15:0] reply_speed = '0;
  logic        tx_ready = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  command;
  logic [7:0]  check_byte;
  logic        frame_sent;
  logic        motor_active;
  logic [15:0] speed_report;
  logic        reversal_pending;
  logic [31:0] error_count;

  interlock_tracker tracker;
  int unsigned burst_left;
  logic [31:0] clock_ms;

  motor_reversal_interlock_unit DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver stalls in stretches: always ready, coin flip, or mostly stalled
  ready_style_t ready_style = READY_ALWAYS;
  int unsigned  stretch_left = 0;

  always @(posedge clk) begin
    if (stretch_left == 0) begin
      ready_style  <= ready_style_t'($urandom_range(0, 2));
      stretch_left <= $urandom_range(5, 60);
      out_ready    <= 1'b1;
    end else begin
      stretch_left <= stretch_left - 1;
      case (ready_style)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default:      out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: every handshake is seen here with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        tracker.take_event({mode, now_ms, on_request, direction_request, reply_framed,
                            reply_active, reply_error, reply_speed, tx_ready});
      if (out_valid && out_ready)
        tracker.check_result({command, check_byte, frame_sent, motor_active, speed_report,
                              reversal_pending, error_count});
    end
  end

  // watchdog on cycles without any transaction
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic mri_pkg::item_t mk(input logic [1:0] m, input logic [31:0] at,
                                        input bit on, input bit dir, input bit framed,
                                        input bit act, input logic [7:0] err,
                                        input logic [15:0] spd, input bit txr);
    mri_pkg::item_t it;
    it.mode              = m;
    it.now_ms            = at;
    it.on_request        = on;
    it.direction_request = dir;
    it.reply_framed      = framed;
    it.reply_active      = act;
    it.reply_error       = err;
    it.reply_speed       = spd;
    it.tx_ready          = txr;
    return it;
  endfunction

  // one event transaction, sender works in bursts with random gaps
  task automatic send_item(input mri_pkg::item_t it);
    mode              <= it.mode;
    now_ms            <= it.now_ms;
    on_request        <= it.on_request;
    direction_request <= it.direction_request;
    reply_framed      <= it.reply_framed;
    reply_active      <= it.reply_active;
    reply_error       <= it.reply_error;
    reply_speed       <= it.reply_speed;
    tx_ready          <= it.tx_ready;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic put_reg(input logic [mri_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all five registers, upper bits of the forbid write are junk on purpose
  task automatic write_regs(input logic [15:0] dwell, input logic [15:0] confirm,
                            input logic [15:0] age, input logic [15:0] report,
                            input logic forbid);
    put_reg(mri_pkg::REG_OFF_DWELL, dwell);
    put_reg(mri_pkg::REG_ZERO_CONFIRM, confirm);
    put_reg(mri_pkg::REG_REPLY_MAX_AGE, age);
    put_reg(mri_pkg::REG_WAIT_REPORT, report);
    put_reg(mri_pkg::REG_FORBID_REV, {15'($urandom), forbid});
    cfg_valid <= 1'b0;
  endtask

  // stop sending and wait until every owed result transaction is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed traffic: set requests, zero-speed replies, transmit slots
  task automatic random_phase(input int unsigned count, input int unsigned step_max);
    mri_pkg::item_t it;
    bit [63:0]      raw;
    int unsigned    roll;
    clock_ms = $urandom;
    for (int unsigned i = 0; i < count; i++) begin
      raw  = {$urandom, $urandom};
      it   = raw[62:0];
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        it.mode       = mri_pkg::MODE_SET;
        it.on_request = ($urandom_range(0, 9) != 0);
      end else if (roll < 50) begin
        it.mode         = mri_pkg::MODE_REPLY;
        it.reply_framed = ($urandom_range(0, 19) != 0);
        if ($urandom_range(0, 3) != 0) begin
          // stopped motor, clean reply
          it.reply_active = 1'b0;
          it.reply_error  = 8'h00;
          it.reply_speed  = 16'h0000;
        end else if ($urandom_range(0, 2) != 0) begin
          it.reply_error = 8'h00;
        end
      end else if (roll < 95) begin
        it.mode     = mri_pkg::MODE_TX;
        it.tx_ready = ($urandom_range(0, 6) != 0);
      end else begin
        it.mode = MODE_UNUSED;
      end
      // time mostly creeps forward, sometimes stalls or jumps anywhere
      roll = $urandom_range(0, 99);
      if (roll < 2) clock_ms = $urandom;
      else if (roll >= 8) clock_ms += $urandom_range(0, step_max);
      it.now_ms = clock_ms;
      send_item(it);
    end
  endtask

  initial begin
    int unsigned age;
    tracker    = new();
    burst_left = $urandom_range(1, 40);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: forward run, full reversal across the time wrap, faults,
    // unframed reply, unused mode, stop, slow reversal report
    send_item(mk(mri_pkg::MODE_SET,   T0,        1, 0, 0, 0, 8'h00, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_TX,    T0 + 10,   0, 0, 0, 0, 8'h00, 16'h0000, 1));
    send_item(mk(mri_pkg::MODE_REPLY, T0 + 20,   0, 0, 1, 1, 8'h00, 16'hFFFF, 0));
    send_item(mk(mri_pkg::MODE_SET,   T0 + 30,   1, 1, 0, 0, 8'h00, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_TX,    T0 + 40,   0, 0, 0, 0, 8'h00, 16'h0000, 1));
    send_item(mk(mri_pkg::MODE_REPLY, T0 + 100,  0, 0, 1, 0, 8'h00, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_TX,    T0 + 200,  0, 0, 0, 0, 8'h00, 16'h0000, 1));
    send_item(mk(mri_pkg::MODE_REPLY, T0 + 400,  0, 0, 1, 0, 8'h00, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_TX,    T0 + 450,  0, 0, 0, 0, 8'h00, 16'h0000, 1));
    send_item(mk(mri_pkg::MODE_REPLY, T0 + 700,  0, 0, 1, 0, 8'h00, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_REPLY, T0 + 1000, 0, 0, 1, 0, 8'h00, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_TX,    T0 + 1100, 0, 0, 0, 0, 8'h00, 16'h0000, 1));
    send_item(mk(mri_pkg::MODE_REPLY, T0 + 1150, 0, 0, 1, 0, 8'hFF, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_TX,    T0 + 1160, 0, 0, 0, 0, 8'h00, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_TX,    T0 + 1170, 0, 0, 0, 0, 8'h00, 16'h0000, 1));
    send_item(mk(mri_pkg::MODE_REPLY, T0 + 1200, 0, 0, 0, 1, 8'h00, 16'h1234, 0));
    send_item(mk(MODE_UNUSED,         32'hFFFF_FFFF, 1, 1, 1, 1, 8'hFF, 16'hFFFF, 1));
    send_item(mk(mri_pkg::MODE_SET,   T0 + 1250, 0, 1, 0, 0, 8'h00, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_SET,   T0 + 1300, 1, 0, 0, 0, 8'h00, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_TX,    T0 + 1310, 0, 0, 0, 0, 8'h00, 16'h0000, 1));
    send_item(mk(mri_pkg::MODE_TX,    T0 + 6310, 0, 0, 0, 0, 8'h00, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_REPLY, T0 + 6400, 0, 0, 1, 0, 8'h00, 16'h0000, 0));
    send_item(mk(mri_pkg::MODE_TX,    T0 + 6500, 0, 0, 0, 0, 8'h00, 16'h0000, 1));

    // random traffic at reset settings
    random_phase(ITEMS_PER_PHASE, 100);
    drain();

    // everything zero: instant reversal, only same-ms replies are fresh
    write_regs(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    random_phase(ITEMS_PER_PHASE, 1);
    drain();

    // everything at maximum, reversal forbidden
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    random_phase(ITEMS_PER_PHASE, 16384);
    drain();

    // moderate random windows that let reversals complete
    age = $urandom_range(200, 2000);
    write_regs(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1000)), 16'(age),
               16'($urandom_range(100, 10000)), 1'b0);
    random_phase(ITEMS_PER_PHASE, age / 3 + 1);
    drain();

    // long dwell, no confirm window, report on every slot
    write_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 1'b0);
    random_phase(ITEMS_PER_PHASE, 16384);
    drain();

    // fully random settings
    age = $urandom_range(0, 65535);
    write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 16'(age),
               16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    random_phase(ITEMS_PER_PHASE, age / 3 + 1);
    drain();

    // back to the reset values, written explicitly
    write_regs(mri_pkg::OFF_DWELL_RST, mri_pkg::ZERO_CONFIRM_RST, mri_pkg::REPLY_MAX_AGE_RST,
               mri_pkg::WAIT_REPORT_RST, 1'b0);
    random_phase(ITEMS_PER_PHASE, 100);
    drain();

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
